>>> sv/art1_pkg.sv
// Package for the ART1 binary clusterer: register codes, state encoding,
// scan status type and the population count helper. No dependencies.
package art1_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int PATTERN_W   = 32;
   localparam int CATEGORY_W  = 5;
   localparam int VIG_W       = 17;
   localparam int LEARN_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_VIGILANCE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LEARN     = CSR_INDEX_W'(1);

   localparam logic [VIG_W-1:0]   VIG_RESET   = VIG_W'(52429);
   localparam logic [LEARN_W-1:0] LEARN_RESET = LEARN_W'(16);
   localparam logic [LEARN_W-1:0] LEARN_MIN   = LEARN_W'(9);
   localparam logic [LEARN_W-1:0] LEARN_ONE   = LEARN_W'(8);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic busy;
      logic found;
      logic was_new;
   } scan_status_type;

   function automatic logic [6:0] popcount64(logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

endpackage

>>> sv/art1_if.sv
// Handshake channels of the ART1 binary clusterer: request, response and
// register write. Depends on art1_pkg for field widths.
interface art1_req_if;
   logic                           valid;
   logic                           ready;
   logic [art1_pkg::PATTERN_W-1:0] pattern;
   modport source (output valid, output pattern, input ready);
   modport sink   (input valid, input pattern, output ready);
endinterface

interface art1_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [art1_pkg::CATEGORY_W-1:0] category;
   logic                            accepted;
   logic                            was_new;
   logic                            zero_input;
   logic [art1_pkg::PATTERN_W-1:0]  prototype;
   modport source (output valid, output category, output accepted, output was_new,
                   output zero_input, output prototype, input ready);
   modport sink   (input valid, input category, input accepted, input was_new,
                   input zero_input, input prototype, output ready);
endinterface

interface art1_csr_if;
   logic                             valid;
   logic                             ready;
   logic [art1_pkg::CSR_INDEX_W-1:0] index;
   logic [art1_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/art1_tmpl_mem.sv
// Category template store with registered read and per-entry trained bits.
// An untrained entry reads as all ones. Depends on nothing.
module art1_tmpl_mem #(
   parameter int PW = 32,
   parameter int C  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [$clog2(C)-1:0] rd_addr,
   output logic [PW-1:0]        rd_data,
   output logic                 rd_trained,
   input  logic                 wr_en,
   input  logic [$clog2(C)-1:0] wr_addr,
   input  logic [PW-1:0]        wr_data
);

   logic [PW-1:0] mem [C];
   logic [C-1:0]  trained_ff;
   logic [PW-1:0] rd_data_ff;
   logic          rd_trained_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trained_ff    <= '0;
         rd_trained_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            trained_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_trained_ff <= trained_ff[rd_addr];
         end
      end
   end

   assign rd_data    = rd_trained_ff ? rd_data_ff : '1;
   assign rd_trained = rd_trained_ff;

endmodule

>>> sv/art1_score_unit.sv
// Shared scoring unit: counts overlap and template size, checks vigilance
// and keeps the best category by exact cross-multiplied compare.
// Depends on art1_pkg.
module art1_score_unit #(
   parameter int PW = 32,
   parameter int C  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             issue,
   input  logic [$clog2(C)-1:0]             issue_idx,
   input  logic [PW-1:0]                    x,
   input  logic [art1_pkg::LEARN_W-1:0]     lq_m8,
   input  logic [art1_pkg::VIG_W+$clog2(PW+1)-1:0] vig_xn,
   input  logic [PW-1:0]                    t,
   input  logic                             t_trained,
   output art1_pkg::scan_status_type        status,
   output logic [$clog2(C)-1:0]             best_idx,
   output logic [PW-1:0]                    best_t
);

   localparam int IW = $clog2(C);
   localparam int CW = $clog2(PW + 1);
   localparam int DW = $clog2(8 * PW + 248);
   localparam int MW = CW + DW;
   localparam int VW = art1_pkg::VIG_W + CW;

   logic          s1_vld_ff;
   logic [IW-1:0] s1_idx_ff;

   logic [CW-1:0] k_s1;
   logic [CW-1:0] tn_s1;
   logic [DW-1:0] d_s1;

   logic          s2_vld_ff;
   logic [IW-1:0] s2_idx_ff;
   logic [CW-1:0] s2_k_ff;
   logic [DW-1:0] s2_d_ff;
   logic [PW-1:0] s2_t_ff;
   logic          s2_new_ff;

   logic          found_ff;
   logic          best_new_ff;
   logic [IW-1:0] best_idx_ff;
   logic [CW-1:0] best_k_ff;
   logic [DW-1:0] best_d_ff;
   logic [PW-1:0] best_t_ff;

   logic [MW-1:0] lhs;
   logic [MW-1:0] rhs;
   logic          pass;
   logic          better;

   assign k_s1  = CW'(art1_pkg::popcount64(64'(x & t)));
   assign tn_s1 = CW'(art1_pkg::popcount64(64'(t)));
   assign d_s1  = DW'(lq_m8) + (DW'(tn_s1) << 3);

   assign lhs    = MW'(s2_k_ff) * MW'(best_d_ff);
   assign rhs    = MW'(best_k_ff) * MW'(s2_d_ff);
   assign pass   = VW'({s2_k_ff, 16'h0000}) >= vig_xn;
   assign better = !found_ff || (lhs > rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (clear) begin
            found_ff <= 1'b0;
         end else if (s2_vld_ff && pass && better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= issue_idx;
      s2_idx_ff <= s1_idx_ff;
      s2_k_ff   <= k_s1;
      s2_d_ff   <= d_s1;
      s2_t_ff   <= t;
      s2_new_ff <= !t_trained;
      if (s2_vld_ff && pass && better) begin
         best_idx_ff <= s2_idx_ff;
         best_k_ff   <= s2_k_ff;
         best_d_ff   <= s2_d_ff;
         best_t_ff   <= s2_t_ff;
         best_new_ff <= s2_new_ff;
      end
   end

   assign status.busy    = s1_vld_ff || s2_vld_ff;
   assign status.found   = found_ff;
   assign status.was_new = best_new_ff;
   assign best_idx       = best_idx_ff;
   assign best_t         = best_t_ff;

endmodule

>>> sv/art1_binary_clusterer_core.sv
// ART1 binary clusterer with fast learning.
// Channels: req_ch takes one 32-bit binary pattern per item; rsp_ch returns
// one result item (category, accepted, was_new, zero_input, prototype);
// csr_ch writes vigilance (index 0) and learn constant (index 1), always ready.
// Operation: the sequencer reads the CATEGORIES templates one a cycle from the
// template store and feeds the shared scoring unit, which checks vigilance and
// keeps the best score; the winner's template is then written back as
// pattern AND template.
// Flow: an all-zero pattern skips the scan. A new item is accepted in the
// cycle after the result is loaded and never while one is in flight, so the
// item rate is set by the single template read port.
// Reset: synchronous, active high; all templates read as all ones and are
// untrained, registers return to vigilance 52429 and learn constant 16.
// Stall: the result waits in an output register; a following item may be
// accepted and scanned meanwhile, and its result is held back until the
// register frees.
module art1_binary_clusterer_core #(
   parameter int PATTERN_BITS = 32,
   parameter int CATEGORIES   = 32
) (
   input  logic       clock,
   input  logic       reset,
   art1_req_if.sink   req_ch,
   art1_rsp_if.source rsp_ch,
   art1_csr_if.sink   csr_ch
);

   localparam int PW = PATTERN_BITS;
   localparam int C  = CATEGORIES;
   localparam int IW = $clog2(C);
   localparam int CW = $clog2(PW + 1);
   localparam int VW = art1_pkg::VIG_W + CW;

   art1_pkg::state_type state_ff, state_in;

   logic [art1_pkg::VIG_W-1:0]   vig_ff;
   logic [art1_pkg::LEARN_W-1:0] learn_ff;
   logic [art1_pkg::LEARN_W-1:0] lq_m8;

   logic [PW-1:0] x_ff;
   logic [CW-1:0] xn_ff;
   logic [VW-1:0] vig_xn_ff;
   logic [IW-1:0] idx_ff;

   logic                        rsp_valid_ff;
   logic [art1_pkg::CATEGORY_W-1:0] rsp_cat_ff;
   logic                        rsp_acc_ff;
   logic                        rsp_new_ff;
   logic                        rsp_zero_ff;
   logic [art1_pkg::PATTERN_W-1:0] rsp_proto_ff;

   logic                        req_fire;
   logic                        issue;
   logic                        last_idx;
   logic                        rsp_load;
   logic                        zero_in;
   logic                        wr_en;
   logic [PW-1:0]               mem_t;
   logic                        mem_trained;
   logic [PW-1:0]               proto;
   logic [IW-1:0]               best_idx;
   logic [PW-1:0]               best_t;
   art1_pkg::scan_status_type   status;

   assign req_ch.ready = (state_ff == art1_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign issue        = (state_ff == art1_pkg::ST_SCAN);
   assign last_idx     = (idx_ff == IW'(C - 1));
   assign zero_in      = (xn_ff == '0);
   assign rsp_load     = (state_ff == art1_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign wr_en        = (state_ff == art1_pkg::ST_WRITE) && status.found;
   assign proto        = x_ff & best_t;
   assign lq_m8        = ((learn_ff < art1_pkg::LEARN_MIN) ? art1_pkg::LEARN_MIN : learn_ff)
                         - art1_pkg::LEARN_ONE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         art1_pkg::ST_IDLE:  if (req_fire) state_in = art1_pkg::ST_PREP;
         art1_pkg::ST_PREP:  state_in = zero_in ? art1_pkg::ST_DONE : art1_pkg::ST_SCAN;
         art1_pkg::ST_SCAN:  if (last_idx) state_in = art1_pkg::ST_DRAIN;
         art1_pkg::ST_DRAIN: if (!status.busy) state_in = art1_pkg::ST_WRITE;
         art1_pkg::ST_WRITE: state_in = art1_pkg::ST_DONE;
         art1_pkg::ST_DONE:  if (rsp_load) state_in = art1_pkg::ST_IDLE;
         default:            state_in = art1_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= art1_pkg::ST_IDLE;
         vig_ff       <= art1_pkg::VIG_RESET;
         learn_ff     <= art1_pkg::LEARN_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               art1_pkg::CSR_VIGILANCE: vig_ff   <= csr_ch.data[art1_pkg::VIG_W-1:0];
               art1_pkg::CSR_LEARN:     learn_ff <= csr_ch.data[art1_pkg::LEARN_W-1:0];
               default: ;
            endcase
         end
         if (issue) begin
            idx_ff <= last_idx ? '0 : idx_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff  <= PW'(req_ch.pattern);
         xn_ff <= CW'(art1_pkg::popcount64(64'(PW'(req_ch.pattern))));
      end
      if (state_ff == art1_pkg::ST_PREP) begin
         vig_xn_ff <= VW'(vig_ff) * VW'(xn_ff);
      end
      if (rsp_load) begin
         rsp_zero_ff <= zero_in;
         if (!zero_in && status.found) begin
            rsp_cat_ff   <= art1_pkg::CATEGORY_W'(best_idx);
            rsp_acc_ff   <= 1'b1;
            rsp_new_ff   <= status.was_new;
            rsp_proto_ff <= art1_pkg::PATTERN_W'(proto);
         end else begin
            rsp_cat_ff   <= '0;
            rsp_acc_ff   <= 1'b0;
            rsp_new_ff   <= 1'b0;
            rsp_proto_ff <= '0;
         end
      end
   end

   art1_tmpl_mem #(
      .PW (PW),
      .C  (C)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (issue),
      .rd_addr    (idx_ff),
      .rd_data    (mem_t),
      .rd_trained (mem_trained),
      .wr_en      (wr_en),
      .wr_addr    (best_idx),
      .wr_data    (proto)
   );

   art1_score_unit #(
      .PW (PW),
      .C  (C)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .clear     (state_ff == art1_pkg::ST_PREP),
      .issue     (issue),
      .issue_idx (idx_ff),
      .x         (x_ff),
      .lq_m8     (lq_m8),
      .vig_xn    (vig_xn_ff),
      .t         (mem_t),
      .t_trained (mem_trained),
      .status    (status),
      .best_idx  (best_idx),
      .best_t    (best_t)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.category   = rsp_cat_ff;
   assign rsp_ch.accepted   = rsp_acc_ff;
   assign rsp_ch.was_new    = rsp_new_ff;
   assign rsp_ch.zero_input = rsp_zero_ff;
   assign rsp_ch.prototype  = rsp_proto_ff;

endmodule
